FILE: hw/rtl/sqp_pkg.sv
package sqp_pkg;

	// fixed widths of the datapath
	localparam int DIST_GUARD = 8;     // extra fraction bits on the distance
	localparam int Q_W        = 33;    // dx*dx + dy*dy
	localparam int ROOT_W     = 25;    // floor(sqrt(q * 2^16))
	localparam int NMAG_W     = 40;    // |d| * radius * 256
	localparam int FMAG_W     = 48;    // |d| * r * R
	localparam int NUM_W      = 49;    // rounded dividend
	localparam int DEN_W      = 34;    // divisor, s or 2q
	localparam int QUO_W      = 17;    // quotient magnitude, at most 65535 for a valid quad
	localparam int LANES      = 6;
	localparam int CORNER_W   = 19;
	localparam int SUM_W      = 21;

	// divider lanes
	localparam int LN_NX = 0;
	localparam int LN_NY = 1;
	localparam int LN_MX = 2;
	localparam int LN_MY = 3;
	localparam int LN_FX = 4;
	localparam int LN_FY = 5;

	localparam logic signed [SUM_W-1:0] CORNER_MAX = 21'sd262143;
	localparam logic signed [SUM_W-1:0] CORNER_MIN = -21'sd262144;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_QUAD    = 2'd1,
		ST_BLOCKED = 2'd2
	} status_t;

	// front end result, rides along the square root pipe
	typedef struct packed {
		logic                blocked;
		logic                noshadow;
		logic signed [16:0]  dx;
		logic signed [16:0]  dy;
		logic signed [15:0]  cx;
		logic signed [15:0]  cy;
		logic [Q_W-1:0]      q;
		logic [NMAG_W-1:0]   num_nx;
		logic [NMAG_W-1:0]   num_ny;
		logic [NMAG_W-1:0]   num_mx;
		logic [NMAG_W-1:0]   num_my;
		logic [FMAG_W-1:0]   num_fx;
		logic [FMAG_W-1:0]   num_fy;
		logic [LANES-1:0]    neg;
	} front_t;

	// rides along the divider pipe
	typedef struct packed {
		status_t             status;
		logic signed [16:0]  dx;
		logic signed [16:0]  dy;
		logic signed [15:0]  cx;
		logic signed [15:0]  cy;
		logic [LANES-1:0]    neg;
	} back_t;

	function automatic logic signed [CORNER_W-1:0] sat_corner(
		input logic signed [SUM_W-1:0] v
	);
		logic signed [CORNER_W-1:0] r;
		if (v > CORNER_MAX) begin
			r = CORNER_MAX[CORNER_W-1:0];
		end else if (v < CORNER_MIN) begin
			r = CORNER_MIN[CORNER_W-1:0];
		end else begin
			r = v[CORNER_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/shadow_quad_projection_unit.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | light_x, light_y, light_radius, caster_x, caster_y,
//         |                      | caster_radius
// out     | out_valid / out_ready| status, corner1_x .. corner4_y
//
// One transaction per cycle while the pipe is not stalled.
// Stages: 3 front end (deltas, products, tests), 25 square root (one root bit each),
// 1 rounding prep, 17 divider (one quotient bit each, six lanes), 1 output.
// Whole pipe advances together; it stalls only while a result sits unread in
// the output register, and in_ready follows that condition.
// Reset clears the valid bits only; payload registers are not reset.
module shadow_quad_projection_unit import sqp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [15:0]         light_x,
	input  logic signed [15:0]         light_y,
	input  logic [15:0]                light_radius,
	input  logic signed [15:0]         caster_x,
	input  logic signed [15:0]         caster_y,
	input  logic [15:0]                caster_radius,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic signed [CORNER_W-1:0] corner1_x,
	output logic signed [CORNER_W-1:0] corner1_y,
	output logic signed [CORNER_W-1:0] corner2_x,
	output logic signed [CORNER_W-1:0] corner2_y,
	output logic signed [CORNER_W-1:0] corner3_x,
	output logic signed [CORNER_W-1:0] corner3_y,
	output logic signed [CORNER_W-1:0] corner4_x,
	output logic signed [CORNER_W-1:0] corner4_y
);

	// global advance: output register empty or being drained
	logic en;
	logic out_valid_s47;

	assign en       = !out_valid_s47 || out_ready;
	assign in_ready = en;

	// front end: dx, dy, q and the blocked / no-shadow tests
	logic   fr_valid;
	front_t fr_data;

	sqp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (in_valid),
		.light_x       (light_x),
		.light_y       (light_y),
		.light_radius  (light_radius),
		.caster_x      (caster_x),
		.caster_y      (caster_y),
		.caster_radius (caster_radius),
		.out_valid     (fr_valid),
		.out_data      (fr_data)
	);

	// s = floor(sqrt(q * 2^(2*guard)))
	logic                sq_valid;
	logic [ROOT_W-1:0]   sq_root;
	front_t              sq_side;
	logic [2*ROOT_W-1:0] sq_rad;

	assign sq_rad = {1'b0, fr_data.q, {(2*DIST_GUARD){1'b0}}};

	sqp_sqrt #(
		.RW (ROOT_W),
		.SW ($bits(front_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.rad       (sq_rad),
		.in_side   (fr_data),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// s29: add half the divisor for round-to-nearest, pick the case
	logic [LANES-1:0][NUM_W-1:0] num_c;
	logic [LANES-1:0][DEN_W-1:0] den_c;
	back_t                       bk_c;

	always_comb begin
		num_c[LN_NX] = NUM_W'(sq_side.num_nx) + NUM_W'(sq_root >> 1);
		num_c[LN_NY] = NUM_W'(sq_side.num_ny) + NUM_W'(sq_root >> 1);
		num_c[LN_MX] = NUM_W'(sq_side.num_mx) + NUM_W'(sq_root >> 1);
		num_c[LN_MY] = NUM_W'(sq_side.num_my) + NUM_W'(sq_root >> 1);
		num_c[LN_FX] = NUM_W'(sq_side.num_fx) + NUM_W'(sq_side.q);
		num_c[LN_FY] = NUM_W'(sq_side.num_fy) + NUM_W'(sq_side.q);
		den_c[LN_NX] = DEN_W'(sq_root);
		den_c[LN_NY] = DEN_W'(sq_root);
		den_c[LN_MX] = DEN_W'(sq_root);
		den_c[LN_MY] = DEN_W'(sq_root);
		den_c[LN_FX] = {sq_side.q, 1'b0};
		den_c[LN_FY] = {sq_side.q, 1'b0};

		// blocked wins over no shadow
		priority if (sq_side.blocked) begin
			bk_c.status = ST_BLOCKED;
		end else if (sq_side.noshadow) begin
			bk_c.status = ST_NONE;
		end else begin
			bk_c.status = ST_QUAD;
		end
		bk_c.dx  = sq_side.dx;
		bk_c.dy  = sq_side.dy;
		bk_c.cx  = sq_side.cx;
		bk_c.cy  = sq_side.cy;
		bk_c.neg = sq_side.neg;
	end

	logic                        vld_s29;
	logic [LANES-1:0][NUM_W-1:0] num_s29;
	logic [LANES-1:0][DEN_W-1:0] den_s29;
	back_t                       bk_s29;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s29 <= 1'b0;
		end else if (en) begin
			vld_s29 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s29 <= num_c;
			den_s29 <= den_c;
			bk_s29  <= bk_c;
		end
	end

	// six divisions in parallel: n and m by s, f by 2q
	logic                        dv_valid;
	logic [LANES-1:0][QUO_W-1:0] dv_quo;
	back_t                       dv_side;

	sqp_div #(
		.L  (LANES),
		.NW (NUM_W),
		.DW (DEN_W),
		.QW (QUO_W),
		.SW ($bits(back_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s29),
		.num       (num_s29),
		.den       (den_s29),
		.in_side   (bk_s29),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.out_side  (dv_side)
	);

	// s47: signs, corner sums, saturation
	logic signed [QUO_W:0]         lane_v [LANES];
	logic signed [SUM_W-1:0]       cx_w, cy_w, mx_w, my_w;
	logic signed [CORNER_W-1:0]    c1x_c, c1y_c, c2x_c, c2y_c, c3x_c, c3y_c, c4x_c, c4y_c;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			lane_v[k] = dv_side.neg[k] ? -$signed({1'b0, dv_quo[k]})
			                           : $signed({1'b0, dv_quo[k]});
		end
		cx_w  = SUM_W'(dv_side.cx);
		cy_w  = SUM_W'(dv_side.cy);
		mx_w  = cx_w + SUM_W'(lane_v[LN_MX]) - SUM_W'(dv_side.dx);
		my_w  = cy_w + SUM_W'(lane_v[LN_MY]) - SUM_W'(dv_side.dy);
		c1x_c = sat_corner(cx_w + SUM_W'(lane_v[LN_NX]));
		c1y_c = sat_corner(cy_w + SUM_W'(lane_v[LN_NY]));
		c2x_c = sat_corner(mx_w + SUM_W'(lane_v[LN_FX]));
		c2y_c = sat_corner(my_w + SUM_W'(lane_v[LN_FY]));
		c3x_c = sat_corner(mx_w - SUM_W'(lane_v[LN_FX]));
		c3y_c = sat_corner(my_w - SUM_W'(lane_v[LN_FY]));
		c4x_c = sat_corner(cx_w - SUM_W'(lane_v[LN_NX]));
		c4y_c = sat_corner(cy_w - SUM_W'(lane_v[LN_NY]));
		// no quad: all corners read zero
		if (dv_side.status != ST_QUAD) begin
			c1x_c = '0;
			c1y_c = '0;
			c2x_c = '0;
			c2y_c = '0;
			c3x_c = '0;
			c3y_c = '0;
			c4x_c = '0;
			c4y_c = '0;
		end
	end

	status_t                    status_s47;
	logic signed [CORNER_W-1:0] c1x_s47, c1y_s47, c2x_s47, c2y_s47;
	logic signed [CORNER_W-1:0] c3x_s47, c3y_s47, c4x_s47, c4y_s47;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s47 <= 1'b0;
		end else if (en) begin
			out_valid_s47 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s47 <= dv_side.status;
			c1x_s47    <= c1x_c;
			c1y_s47    <= c1y_c;
			c2x_s47    <= c2x_c;
			c2y_s47    <= c2y_c;
			c3x_s47    <= c3x_c;
			c3y_s47    <= c3y_c;
			c4x_s47    <= c4x_c;
			c4y_s47    <= c4y_c;
		end
	end

	assign out_valid = out_valid_s47;
	assign status    = status_s47;
	assign corner1_x = c1x_s47;
	assign corner1_y = c1y_s47;
	assign corner2_x = c2x_s47;
	assign corner2_y = c2y_s47;
	assign corner3_x = c3x_s47;
	assign corner3_y = c3y_s47;
	assign corner4_x = c4x_s47;
	assign corner4_y = c4y_s47;

	// near corners straddle the caster centre: their sum is 2*C, always even
	logic signed [CORNER_W:0] near_x_sum, near_y_sum;

	assign near_x_sum = corner1_x + corner4_x;
	assign near_y_sum = corner1_y + corner4_y;

	a_near_sym: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_QUAD) |-> (!near_x_sum[0] && !near_y_sum[0]))
		else $error("near corners not symmetric about caster centre");

	a_zero_corners: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_QUAD) |->
		(corner1_x == '0 && corner2_y == '0 && corner3_x == '0 && corner4_y == '0))
		else $error("corners nonzero without a quad");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(corner2_x) && $stable(status)))
		else $error("stalled result changed");

endmodule

FILE: hw/rtl/sqp_front.sv
module sqp_front import sqp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [15:0] light_x,
	input  logic signed [15:0] light_y,
	input  logic [15:0]        light_radius,
	input  logic signed [15:0] caster_x,
	input  logic signed [15:0] caster_y,
	input  logic [15:0]        caster_radius,
	output logic               out_valid,
	output front_t             out_data
);

	// s1: deltas and magnitudes
	logic signed [16:0] dx_c, dy_c;
	logic [15:0]        adx_c, ady_c;

	assign dx_c  = 17'(caster_x) - 17'(light_x);
	assign dy_c  = 17'(caster_y) - 17'(light_y);
	assign adx_c = dx_c[16] ? 16'(-dx_c) : dx_c[15:0];
	assign ady_c = dy_c[16] ? 16'(-dy_c) : dy_c[15:0];

	logic               vld_s1;
	logic [15:0]        adx_s1, ady_s1, rc_s1, rl_s1;
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [15:0] cx_s1, cy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1 <= adx_c;
			ady_s1 <= ady_c;
			rc_s1  <= caster_radius;
			rl_s1  <= light_radius;
			dx_s1  <= dx_c;
			dy_s1  <= dy_c;
			cx_s1  <= caster_x;
			cy_s1  <= caster_y;
		end
	end

	// s2: 16x16 products
	logic               vld_s2;
	logic [31:0]        xx_s2, yy_s2, cc_s2, ll_s2;
	logic [31:0]        xc_s2, yc_s2, xl_s2, yl_s2, cl_s2;
	logic [15:0]        ady_s2, adx_s2;
	logic signed [16:0] dx_s2, dy_s2;
	logic signed [15:0] cx_s2, cy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2  <= 32'(adx_s1) * 32'(adx_s1);
			yy_s2  <= 32'(ady_s1) * 32'(ady_s1);
			cc_s2  <= 32'(rc_s1) * 32'(rc_s1);
			ll_s2  <= 32'(rl_s1) * 32'(rl_s1);
			xc_s2  <= 32'(adx_s1) * 32'(rc_s1);
			yc_s2  <= 32'(ady_s1) * 32'(rc_s1);
			xl_s2  <= 32'(adx_s1) * 32'(rl_s1);
			yl_s2  <= 32'(ady_s1) * 32'(rl_s1);
			cl_s2  <= 32'(rc_s1) * 32'(rl_s1);
			adx_s2 <= adx_s1;
			ady_s2 <= ady_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
		end
	end

	// s3: squared distance, case tests, far-edge numerators
	logic [Q_W-1:0] q_c;
	front_t         nxt_c;

	assign q_c = Q_W'(xx_s2) + Q_W'(yy_s2);

	always_comb begin
		nxt_c          = '0;
		nxt_c.blocked  = (q_c == '0) || ({q_c, 2'b00} < (Q_W + 2)'(cc_s2));
		nxt_c.noshadow = q_c >= Q_W'(ll_s2);
		nxt_c.dx       = dx_s2;
		nxt_c.dy       = dy_s2;
		nxt_c.cx       = cx_s2;
		nxt_c.cy       = cy_s2;
		nxt_c.q        = q_c;
		nxt_c.num_nx   = {yc_s2, {DIST_GUARD{1'b0}}};
		nxt_c.num_ny   = {xc_s2, {DIST_GUARD{1'b0}}};
		nxt_c.num_mx   = {xl_s2, {DIST_GUARD{1'b0}}};
		nxt_c.num_my   = {yl_s2, {DIST_GUARD{1'b0}}};
		nxt_c.num_fx   = FMAG_W'(cl_s2) * FMAG_W'(ady_s2);
		nxt_c.num_fy   = FMAG_W'(cl_s2) * FMAG_W'(adx_s2);
		// n and f point along (-dy, dx)
		nxt_c.neg[LN_NX] = ~dy_s2[16];
		nxt_c.neg[LN_NY] = dx_s2[16];
		nxt_c.neg[LN_MX] = dx_s2[16];
		nxt_c.neg[LN_MY] = dy_s2[16];
		nxt_c.neg[LN_FX] = ~dy_s2[16];
		nxt_c.neg[LN_FY] = dx_s2[16];
	end

	logic   vld_s3;
	front_t data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3 <= nxt_c;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = data_s3;

endmodule

FILE: hw/rtl/sqp_sqrt.sv
module sqp_sqrt import sqp_pkg::*; #(
	parameter int RW = 25,
	parameter int SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] rad,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   out_side
);

	localparam int REMW = RW + 2;

	// one result bit per stage, most significant first
	logic              vld_s  [RW];
	logic [REMW-1:0]   rem_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [2*RW-1:0]   rad_s  [RW];
	logic [SW-1:0]     side_s [RW];

	for (genvar j = 0; j < RW; j++) begin : g_stage
		localparam int P = RW - 1 - j;
		logic            v_in;
		logic [REMW-1:0] rem_in;
		logic [RW-1:0]   root_in;
		logic [2*RW-1:0] rad_in;
		logic [SW-1:0]   side_in;
		logic [REMW+1:0] pre, trial;
		logic            ge;

		if (j == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign rad_in  = rad_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign pre   = {rem_in, rad_in[2*P+1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = pre >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? REMW'(pre - trial) : pre[REMW-1:0];
				root_s[j] <= {root_in[RW-2:0], ge};
				rad_s[j]  <= rad_in;
				side_s[j] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign out_side  = side_s[RW-1];

endmodule

FILE: hw/rtl/sqp_div.sv
module sqp_div import sqp_pkg::*; #(
	parameter int L  = 6,
	parameter int NW = 49,
	parameter int DW = 34,
	parameter int QW = 17,
	parameter int SW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [L-1:0][NW-1:0]   num,
	input  logic [L-1:0][DW-1:0]   den,
	input  logic [SW-1:0]          in_side,
	output logic                   out_valid,
	output logic [L-1:0][QW-1:0]   quo,
	output logic [SW-1:0]          out_side
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	// restoring division, one quotient bit per stage in every lane
	logic                 vld_s  [QW];
	logic [L-1:0][NW-1:0] rem_s  [QW];
	logic [L-1:0][DW-1:0] den_s  [QW];
	logic [L-1:0][QW-1:0] quo_s  [QW];
	logic [SW-1:0]        side_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int B = QW - 1 - j;
		logic                 v_in;
		logic [L-1:0][NW-1:0] rem_in, rem_nx;
		logic [L-1:0][DW-1:0] den_in;
		logic [L-1:0][QW-1:0] quo_in, quo_nx;
		logic [SW-1:0]        side_in;

		if (j == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = num;
			assign den_in  = den;
			assign quo_in  = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign den_in  = den_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign side_in = side_s[j-1];
		end

		always_comb begin
			logic [CW-1:0] dsh;
			logic          ge;
			for (int k = 0; k < L; k++) begin
				dsh       = CW'(den_in[k]) << B;
				ge        = CW'(rem_in[k]) >= dsh;
				rem_nx[k] = ge ? (rem_in[k] - dsh[NW-1:0]) : rem_in[k];
				quo_nx[k] = {quo_in[k][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rem_nx;
				den_s[j]  <= den_in;
				quo_s[j]  <= quo_nx;
				side_s[j] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule
